>>> sv/obrh_pkg.sv
// ----------------------------------------------------------------------------
// obrh_pkg: shared types and constants for the oriented box ray hit test
// Fixed-point widths, register codes, queue entry layout, arithmetic helpers.
// ----------------------------------------------------------------------------
package obrh_pkg;

	// coordinate formats
	localparam int COORD_W  = 32;                  // port width of a coordinate
	localparam int SAT_W    = 42;                  // saturated coordinate, +-2^40
	localparam int LOC_W    = 44;                  // offsets and box-space values
	localparam int TRIG_W   = 18;                  // sine and cosine, Q2.16
	localparam int PROD_W   = TRIG_W + LOC_W;      // one rotation product
	localparam int SUM_W    = PROD_W + 1;          // sum of two products
	localparam int FRAC_W   = 16;                  // Q16.16 fraction bits
	localparam int SLAB_SH  = 15;                  // slab numerator scale 2^15
	localparam int M_W      = LOC_W + 2;           // +-extent - 2*o
	localparam int NUM_W    = M_W - 1 + SLAB_SH;   // dividend magnitude
	localparam int DEN_W    = LOC_W;               // divisor magnitude
	localparam int Q_W      = NUM_W + 1;           // signed quotient
	localparam int T_W      = 64;                  // interval bounds
	localparam int DIV_LAT  = NUM_W + 1;           // divider register stages
	localparam int EXT_W    = 31;                  // box width and depth
	localparam int ANG_W    = 16;                  // angle register
	localparam int CFG_W    = (COORD_W > 32) ? COORD_W : 32;
	localparam int IDX_W    = 3;
	localparam int Q_DEPTH  = 4;
	localparam int QPTR_W   = $clog2(Q_DEPTH);
	localparam int QCNT_W   = $clog2(Q_DEPTH + 1);
	localparam int ROUND_HALF = 32768;

	localparam longint SAT_LIM     = 64'sd1 <<< 40;
	localparam longint T_UNBOUNDED = 64'sd1 <<< 62;
	localparam int     HALF_Y_FULL = 6554;

	// register reset values
	localparam logic [ANG_W-1:0] RST_TILT  = 16'd5461;
	localparam logic [ANG_W-1:0] RST_AZIM  = 16'd32768;
	localparam logic [EXT_W-1:0] RST_WIDTH = 31'd131072;
	localparam logic [EXT_W-1:0] RST_DEPTH = 31'd98304;

	// configuration register indexes
	typedef enum logic [IDX_W-1:0] {
		REG_POS_X  = 3'd0,
		REG_POS_Y  = 3'd1,
		REG_POS_Z  = 3'd2,
		REG_TILT   = 3'd3,
		REG_AZIM   = 3'd4,
		REG_WIDTH  = 3'd5,
		REG_DEPTH  = 3'd6
	} reg_idx_t;

	// rotation coefficients
	typedef struct packed {
		logic signed [TRIG_W-1:0] ct;
		logic signed [TRIG_W-1:0] st;
		logic signed [TRIG_W-1:0] ca;
		logic signed [TRIG_W-1:0] sa;
	} trig_t;

	// one slab axis: both numerators and the direction component
	typedef struct packed {
		logic signed [M_W-1:0]   ma;
		logic signed [M_W-1:0]   mb;
		logic signed [LOC_W-1:0] d;
	} axis_t;

	typedef axis_t [2:0] q_entry_t;

	// queue status toward front and back
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	// sign extend and clamp a coordinate to +-2^40
	function automatic logic signed [SAT_W-1:0] sat_coord(input logic [COORD_W-1:0] v);
		logic signed [63:0] e;
		e = 64'(signed'(v));
		if (e > SAT_LIM)
			e = SAT_LIM;
		else if (e < -SAT_LIM)
			e = -SAT_LIM;
		return SAT_W'(e);
	endfunction

	// coefficient times coordinate at full width
	function automatic logic signed [PROD_W-1:0] smul(input logic signed [TRIG_W-1:0] c,
			input logic signed [LOC_W-1:0] v);
		return PROD_W'(c) * PROD_W'(v);
	endfunction

	// p +- q, rounded half up to Q16.16
	function automatic logic signed [LOC_W-1:0] rnd16(input logic signed [PROD_W-1:0] p,
			input logic signed [PROD_W-1:0] q, input logic sub);
		logic signed [SUM_W-1:0] s;
		s = sub ? (SUM_W'(p) - SUM_W'(q)) : (SUM_W'(p) + SUM_W'(q));
		s = s + SUM_W'(ROUND_HALF);
		return signed'(s[FRAC_W +: LOC_W]);
	endfunction

endpackage

>>> sv/obrh_trig.sv
// ----------------------------------------------------------------------------
// obrh_trig: sine and cosine of tilt and azimuth
// Two CORDIC lanes iterated 16 steps after reset and after each register write.
// ----------------------------------------------------------------------------
module obrh_trig (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [obrh_pkg::ANG_W-1:0] tilt,
	input  logic [obrh_pkg::ANG_W-1:0] azim,
	output logic                       rdy,
	output obrh_pkg::trig_t            trig
);
	import obrh_pkg::*;

	localparam int CX_W   = 34;
	localparam int ANGR_W = 18;
	localparam int CORD_N = 16;
	localparam int CNT_W  = $clog2(CORD_N);
	localparam int RND_SH = 14;
	localparam logic [CNT_W-1:0]        CNT_LAST = CNT_W'(CORD_N - 1);
	localparam logic signed [CX_W-1:0]   GAIN    = CX_W'(652032874);
	localparam logic signed [CX_W-1:0]   RND     = CX_W'(8192);
	localparam logic signed [ANGR_W-1:0] QTR     = ANGR_W'(16384);
	localparam logic signed [ANGR_W-1:0] HALF    = ANGR_W'(32768);
	localparam logic signed [ANGR_W-1:0] ATAN [CORD_N] = '{
		18'sd8192, 18'sd4836, 18'sd2555, 18'sd1297, 18'sd651, 18'sd326, 18'sd163, 18'sd81,
		18'sd41, 18'sd20, 18'sd10, 18'sd5, 18'sd3, 18'sd1, 18'sd1, 18'sd0
	};

	typedef enum logic [3:0] {
		TS_LOAD = 4'b0001,
		TS_RUN  = 4'b0010,
		TS_FIN  = 4'b0100,
		TS_IDLE = 4'b1000
	} trig_state_t;

	trig_state_t state_q;
	logic [CNT_W-1:0] cnt_q;

	logic signed [CX_W-1:0]   x_q [2];
	logic signed [CX_W-1:0]   y_q [2];
	logic signed [ANGR_W-1:0] a_q [2];
	logic                     neg_q [2];
	logic signed [TRIG_W-1:0] cos_q [2];
	logic signed [TRIG_W-1:0] sin_q [2];

	logic signed [CX_W-1:0]   x_n [2];
	logic signed [CX_W-1:0]   y_n [2];
	logic signed [ANGR_W-1:0] a_n [2];
	logic signed [ANGR_W-1:0] red_a [2];
	logic                     red_neg [2];
	logic signed [TRIG_W-1:0] cos_n [2];
	logic signed [TRIG_W-1:0] sin_n [2];

	// angle reduction, one rotation step and final rounding per lane
	always_comb begin
		logic signed [ANGR_W-1:0] ar;
		logic signed [CX_W-1:0]   sx;
		logic signed [CX_W-1:0]   sy;
		logic signed [CX_W-1:0]   tx;
		logic signed [CX_W-1:0]   ty;
		logic signed [TRIG_W-1:0] rx;
		logic signed [TRIG_W-1:0] ry;
		for (int l = 0; l < 2; l++) begin
			ar = ANGR_W'(signed'((l == 0) ? tilt : azim));
			red_a[l]   = ar;
			red_neg[l] = 1'b0;
			if (ar > QTR) begin
				red_a[l]   = ar - HALF;
				red_neg[l] = 1'b1;
			end else if (ar < -QTR) begin
				red_a[l]   = ar + HALF;
				red_neg[l] = 1'b1;
			end
			sx = x_q[l] >>> cnt_q;
			sy = y_q[l] >>> cnt_q;
			if (!a_q[l][ANGR_W-1]) begin
				x_n[l] = x_q[l] - sy;
				y_n[l] = y_q[l] + sx;
				a_n[l] = a_q[l] - ATAN[cnt_q];
			end else begin
				x_n[l] = x_q[l] + sy;
				y_n[l] = y_q[l] - sx;
				a_n[l] = a_q[l] + ATAN[cnt_q];
			end
			tx = x_q[l] + RND;
			ty = y_q[l] + RND;
			rx = signed'(tx[RND_SH +: TRIG_W]);
			ry = signed'(ty[RND_SH +: TRIG_W]);
			cos_n[l] = neg_q[l] ? -rx : rx;
			sin_n[l] = neg_q[l] ? -ry : ry;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= TS_LOAD;
			cnt_q   <= '0;
		end else if (start) begin
			state_q <= TS_LOAD;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				TS_LOAD: begin
					state_q <= TS_RUN;
					cnt_q   <= '0;
				end
				TS_RUN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_LAST)
						state_q <= TS_FIN;
				end
				TS_FIN:  state_q <= TS_IDLE;
				TS_IDLE: state_q <= TS_IDLE;
				default: state_q <= TS_LOAD;
			endcase
		end
	end

	// lane datapath
	always_ff @(posedge clk) begin
		for (int l = 0; l < 2; l++) begin
			if (state_q == TS_LOAD) begin
				x_q[l]   <= GAIN;
				y_q[l]   <= '0;
				a_q[l]   <= red_a[l];
				neg_q[l] <= red_neg[l];
			end else if (state_q == TS_RUN) begin
				x_q[l] <= x_n[l];
				y_q[l] <= y_n[l];
				a_q[l] <= a_n[l];
			end
			if (state_q == TS_FIN) begin
				cos_q[l] <= cos_n[l];
				sin_q[l] <= sin_n[l];
			end
		end
	end

	assign rdy     = (state_q == TS_IDLE);
	assign trig.ct = cos_q[0];
	assign trig.st = sin_q[0];
	assign trig.ca = cos_q[1];
	assign trig.sa = sin_q[1];

endmodule

>>> sv/obrh_front.sv
// ----------------------------------------------------------------------------
// obrh_front: ray intake and transform to box space
// Offsets the origin, applies both inverse rotations and forms slab numerators.
// ----------------------------------------------------------------------------
module obrh_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         acc,
	input  logic [obrh_pkg::COORD_W-1:0] origin_x,
	input  logic [obrh_pkg::COORD_W-1:0] origin_y,
	input  logic [obrh_pkg::COORD_W-1:0] origin_z,
	input  logic [obrh_pkg::COORD_W-1:0] dir_x,
	input  logic [obrh_pkg::COORD_W-1:0] dir_y,
	input  logic [obrh_pkg::COORD_W-1:0] dir_z,
	input  logic [obrh_pkg::COORD_W-1:0] pos_x,
	input  logic [obrh_pkg::COORD_W-1:0] pos_y,
	input  logic [obrh_pkg::COORD_W-1:0] pos_z,
	input  logic [obrh_pkg::EXT_W-1:0]   width,
	input  logic [obrh_pkg::EXT_W-1:0]   depth,
	input  obrh_pkg::trig_t              trig,
	input  obrh_pkg::q_stat_t            qs,
	output logic                         en,
	output logic                         push,
	output obrh_pkg::q_entry_t           entry
);
	import obrh_pkg::*;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;

	logic signed [LOC_W-1:0]  o_s1 [3];
	logic signed [LOC_W-1:0]  d_s1 [3];
	logic signed [LOC_W-1:0]  ox_s2, dx_s2;
	logic signed [PROD_W-1:0] po_s2 [4];
	logic signed [PROD_W-1:0] pd_s2 [4];
	logic signed [LOC_W-1:0]  ox_s3, dx_s3, oy_s3, dy_s3, oz_s3, dz_s3;
	logic signed [LOC_W-1:0]  oy_s4, dy_s4;
	logic signed [PROD_W-1:0] po_s4 [4];
	logic signed [PROD_W-1:0] pd_s4 [4];
	logic signed [LOC_W-1:0]  ol_s5 [3];
	logic signed [LOC_W-1:0]  dl_s5 [3];
	q_entry_t                 entry_s6;
	q_entry_t                 entry_c;

	assign en   = !vld_s6 || !qs.full;
	assign push = vld_s6 && !qs.full;

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s1 <= acc;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	// slab numerators from box-space values
	always_comb begin
		logic signed [M_W-1:0] ext;
		logic signed [M_W-1:0] two_o;
		for (int k = 0; k < 3; k++) begin
			if (k == 0)
				ext = signed'(M_W'(width));
			else if (k == 1)
				ext = M_W'(HALF_Y_FULL);
			else
				ext = signed'(M_W'(depth));
			two_o = M_W'(ol_s5[k]) <<< 1;
			entry_c[k].ma = -ext - two_o;
			entry_c[k].mb = ext - two_o;
			entry_c[k].d  = dl_s5[k];
		end
	end

	// transform pipeline
	always_ff @(posedge clk) begin
		if (en) begin
			// offset and saturate
			o_s1[0] <= LOC_W'(sat_coord(origin_x)) - LOC_W'(sat_coord(pos_x));
			o_s1[1] <= LOC_W'(sat_coord(origin_y)) - LOC_W'(sat_coord(pos_y));
			o_s1[2] <= LOC_W'(sat_coord(origin_z)) - LOC_W'(sat_coord(pos_z));
			d_s1[0] <= LOC_W'(sat_coord(dir_x));
			d_s1[1] <= LOC_W'(sat_coord(dir_y));
			d_s1[2] <= LOC_W'(sat_coord(dir_z));
			// tilt products
			ox_s2    <= o_s1[0];
			dx_s2    <= d_s1[0];
			po_s2[0] <= smul(trig.ct, o_s1[1]);
			po_s2[1] <= smul(trig.st, o_s1[2]);
			po_s2[2] <= smul(trig.ct, o_s1[2]);
			po_s2[3] <= smul(trig.st, o_s1[1]);
			pd_s2[0] <= smul(trig.ct, d_s1[1]);
			pd_s2[1] <= smul(trig.st, d_s1[2]);
			pd_s2[2] <= smul(trig.ct, d_s1[2]);
			pd_s2[3] <= smul(trig.st, d_s1[1]);
			// tilt sums
			ox_s3 <= ox_s2;
			dx_s3 <= dx_s2;
			oy_s3 <= rnd16(po_s2[0], po_s2[1], 1'b0);
			oz_s3 <= rnd16(po_s2[2], po_s2[3], 1'b1);
			dy_s3 <= rnd16(pd_s2[0], pd_s2[1], 1'b0);
			dz_s3 <= rnd16(pd_s2[2], pd_s2[3], 1'b1);
			// azimuth products
			oy_s4    <= oy_s3;
			dy_s4    <= dy_s3;
			po_s4[0] <= smul(trig.ca, ox_s3);
			po_s4[1] <= smul(trig.sa, oz_s3);
			po_s4[2] <= smul(trig.sa, ox_s3);
			po_s4[3] <= smul(trig.ca, oz_s3);
			pd_s4[0] <= smul(trig.ca, dx_s3);
			pd_s4[1] <= smul(trig.sa, dz_s3);
			pd_s4[2] <= smul(trig.sa, dx_s3);
			pd_s4[3] <= smul(trig.ca, dz_s3);
			// azimuth sums
			ol_s5[0] <= rnd16(po_s4[0], po_s4[1], 1'b1);
			ol_s5[1] <= oy_s4;
			ol_s5[2] <= rnd16(po_s4[2], po_s4[3], 1'b0);
			dl_s5[0] <= rnd16(pd_s4[0], pd_s4[1], 1'b1);
			dl_s5[1] <= dy_s4;
			dl_s5[2] <= rnd16(pd_s4[2], pd_s4[3], 1'b0);
			// queue entry
			entry_s6 <= entry_c;
		end
	end

	assign entry = entry_s6;

endmodule

>>> sv/obrh_queue.sv
// ----------------------------------------------------------------------------
// obrh_queue: short queue between front and back
// Four entries; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module obrh_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  obrh_pkg::q_entry_t wdata,
	input  logic               pop,
	output obrh_pkg::q_entry_t head,
	output obrh_pkg::q_stat_t  qs
);
	import obrh_pkg::*;

	q_entry_t            mem_q [Q_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0]   cnt_q;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wdata;
	end

	assign head     = mem_q[rd_ptr_q];
	assign qs.full  = (cnt_q == QCNT_W'(Q_DEPTH));
	assign qs.empty = (cnt_q == '0);

endmodule

>>> sv/obrh_div.sv
// ----------------------------------------------------------------------------
// obrh_div: pipelined signed divider, truncating toward zero
// Input register, then one restoring quotient bit per stage.
// ----------------------------------------------------------------------------
module obrh_div (
	input  logic                              clk,
	input  logic                              en,
	input  logic [obrh_pkg::NUM_W-1:0]        num,
	input  logic [obrh_pkg::DEN_W-1:0]        den,
	input  logic                              neg,
	output logic signed [obrh_pkg::Q_W-1:0]   quo
);
	import obrh_pkg::*;

	logic [DEN_W-1:0] rem_s [DIV_LAT];
	logic [NUM_W-1:0] nq_s  [DIV_LAT];
	logic [DEN_W-1:0] den_s [DIV_LAT];
	logic             neg_s [DIV_LAT];

	logic [DEN_W-1:0] rem_n [DIV_LAT];
	logic [NUM_W-1:0] nq_n  [DIV_LAT];

	logic signed [Q_W-1:0] mag;

	// compare and subtract per stage
	always_comb begin
		logic [DEN_W:0] tmp;
		logic [DEN_W:0] dif;
		rem_n[0] = '0;
		nq_n[0]  = '0;
		for (int k = 1; k < DIV_LAT; k++) begin
			tmp = {rem_s[k-1], nq_s[k-1][NUM_W-1]};
			dif = tmp - {1'b0, den_s[k-1]};
			if (tmp >= {1'b0, den_s[k-1]}) begin
				rem_n[k] = dif[DEN_W-1:0];
				nq_n[k]  = {nq_s[k-1][NUM_W-2:0], 1'b1};
			end else begin
				rem_n[k] = tmp[DEN_W-1:0];
				nq_n[k]  = {nq_s[k-1][NUM_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= '0;
			nq_s[0]  <= num;
			den_s[0] <= den;
			neg_s[0] <= neg;
			for (int k = 1; k < DIV_LAT; k++) begin
				rem_s[k] <= rem_n[k];
				nq_s[k]  <= nq_n[k];
				den_s[k] <= den_s[k-1];
				neg_s[k] <= neg_s[k-1];
			end
		end
	end

	assign mag = signed'(Q_W'(nq_s[DIV_LAT-1]));
	assign quo = neg_s[DIV_LAT-1] ? -mag : mag;

endmodule

>>> sv/obrh_back.sv
// ----------------------------------------------------------------------------
// obrh_back: slab distances and hit decision
// Six dividers, per-axis intervals, then interval overlap into the output item.
// ----------------------------------------------------------------------------
module obrh_back (
	input  logic               clk,
	input  logic               arst_n,
	input  obrh_pkg::q_stat_t  qs,
	input  obrh_pkg::q_entry_t head,
	input  logic               out_ready,
	output logic               pop,
	output logic               out_valid,
	output logic               hit
);
	import obrh_pkg::*;

	logic en;

	logic [NUM_W-1:0] num_a [3];
	logic [NUM_W-1:0] num_b [3];
	logic [DEN_W-1:0] den_c [3];
	logic             neg_a [3];
	logic             neg_b [3];
	logic [2:0]       zero_c, in_c;

	logic signed [Q_W-1:0] q_a [3];
	logic signed [Q_W-1:0] q_b [3];

	logic       div_vld_s  [DIV_LAT];
	logic [2:0] div_zero_s [DIV_LAT];
	logic [2:0] div_in_s   [DIV_LAT];

	logic                  vld_s1, ok_s1;
	logic signed [T_W-1:0] lo_s1 [3];
	logic signed [T_W-1:0] hi_s1 [3];

	logic out_valid_q, hit_q;
	logic signed [T_W-1:0] lo_max, hi_min;

	assign en  = !out_valid_q || out_ready;
	assign pop = en && !qs.empty;

	// divider operands from the queue head
	always_comb begin
		logic signed [M_W-1:0]   ma, mb;
		logic signed [LOC_W-1:0] d;
		logic [M_W-1:0]          abs_a, abs_b;
		logic [LOC_W-1:0]        abs_d;
		for (int k = 0; k < 3; k++) begin
			ma = head[k].ma;
			mb = head[k].mb;
			d  = head[k].d;
			abs_a = ma[M_W-1] ? M_W'(-ma) : M_W'(ma);
			abs_b = mb[M_W-1] ? M_W'(-mb) : M_W'(mb);
			abs_d = d[LOC_W-1] ? LOC_W'(-d) : LOC_W'(d);
			num_a[k] = {abs_a[M_W-2:0], {SLAB_SH{1'b0}}};
			num_b[k] = {abs_b[M_W-2:0], {SLAB_SH{1'b0}}};
			den_c[k] = abs_d;
			neg_a[k] = ma[M_W-1] ^ d[LOC_W-1];
			neg_b[k] = mb[M_W-1] ^ d[LOC_W-1];
			zero_c[k] = (d == '0);
			in_c[k]   = (ma[M_W-1] || (ma == '0)) && !mb[M_W-1];
		end
	end

	// two dividers per axis
	for (genvar k = 0; k < 3; k++) begin : g_axis
		obrh_div u_div_a (
			.clk (clk),
			.en  (en),
			.num (num_a[k]),
			.den (den_c[k]),
			.neg (neg_a[k]),
			.quo (q_a[k])
		);
		obrh_div u_div_b (
			.clk (clk),
			.en  (en),
			.num (num_b[k]),
			.den (den_c[k]),
			.neg (neg_b[k]),
			.quo (q_b[k])
		);
	end

	// control along the divider
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DIV_LAT; k++)
				div_vld_s[k] <= 1'b0;
			vld_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			div_vld_s[0] <= pop;
			for (int k = 1; k < DIV_LAT; k++)
				div_vld_s[k] <= div_vld_s[k-1];
			vld_s1      <= div_vld_s[DIV_LAT-1];
			out_valid_q <= vld_s1;
		end
	end

	// axis flags delay, intervals per axis
	always_ff @(posedge clk) begin
		if (en) begin
			div_zero_s[0] <= zero_c;
			div_in_s[0]   <= in_c;
			for (int k = 1; k < DIV_LAT; k++) begin
				div_zero_s[k] <= div_zero_s[k-1];
				div_in_s[k]   <= div_in_s[k-1];
			end
			ok_s1 <= 1'b1;
			for (int k = 0; k < 3; k++) begin
				if (div_zero_s[DIV_LAT-1][k]) begin
					lo_s1[k] <= -T_UNBOUNDED;
					hi_s1[k] <= T_UNBOUNDED;
					if (!div_in_s[DIV_LAT-1][k])
						ok_s1 <= 1'b0;
				end else if (q_a[k] < q_b[k]) begin
					lo_s1[k] <= T_W'(q_a[k]);
					hi_s1[k] <= T_W'(q_b[k]);
				end else begin
					lo_s1[k] <= T_W'(q_b[k]);
					hi_s1[k] <= T_W'(q_a[k]);
				end
			end
			hit_q <= ok_s1 && (lo_max <= hi_min) && (hi_min > 0);
		end
	end

	// overlap of the three intervals
	always_comb begin
		lo_max = lo_s1[0];
		hi_min = hi_s1[0];
		for (int k = 1; k < 3; k++) begin
			if (lo_s1[k] > lo_max)
				lo_max = lo_s1[k];
			if (hi_s1[k] < hi_min)
				hi_min = hi_s1[k];
		end
	end

	assign out_valid = out_valid_q;
	assign hit       = hit_q;

endmodule

>>> sv/oriented_box_ray_hit_test.sv
// ----------------------------------------------------------------------------
// oriented_box_ray_hit_test: ray against one tilted and turned box
// Front transforms rays into box space, a queue decouples it from the back,
// which runs the slab test through pipelined dividers.
//
//   channel | signals                                  | direction
//   --------+------------------------------------------+----------
//   in      | in_valid in_ready origin_x..z dir_x..z   | ray in
//   out     | out_valid out_ready hit                  | result out
//   cfg     | cfg_valid cfg_ready cfg_index cfg_data   | register write
//
// One ray per cycle while in_ready is high; 6 front stages, the queue,
// 61 divider stages and 2 interval stages lie between input and output.
// After reset and after each register write the CORDIC unit runs its load,
// iteration and rounding states, and in_ready stays low meanwhile.
// A stalled output halts the back pipeline; the 4-entry queue then fills,
// and the front stalls in turn, which drops in_ready.
// ----------------------------------------------------------------------------
module oriented_box_ray_hit_test (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [obrh_pkg::COORD_W-1:0] origin_x,
	input  logic [obrh_pkg::COORD_W-1:0] origin_y,
	input  logic [obrh_pkg::COORD_W-1:0] origin_z,
	input  logic [obrh_pkg::COORD_W-1:0] dir_x,
	input  logic [obrh_pkg::COORD_W-1:0] dir_y,
	input  logic [obrh_pkg::COORD_W-1:0] dir_z,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         hit,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [obrh_pkg::IDX_W-1:0]   cfg_index,
	input  logic [obrh_pkg::CFG_W-1:0]   cfg_data
);
	import obrh_pkg::*;

	logic [COORD_W-1:0] pos_x_q, pos_y_q, pos_z_q;
	logic [ANG_W-1:0]   tilt_q, azim_q;
	logic [EXT_W-1:0]   width_q, depth_q;

	logic     cfg_wr, trig_rdy, f_en, acc, q_push, q_pop;
	trig_t    trig;
	q_stat_t  q_stat;
	q_entry_t q_wdata, q_head;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign in_ready  = f_en && trig_rdy && !cfg_valid;
	assign acc       = in_valid && in_ready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q <= '0;
			pos_y_q <= '0;
			pos_z_q <= '0;
			tilt_q  <= RST_TILT;
			azim_q  <= RST_AZIM;
			width_q <= RST_WIDTH;
			depth_q <= RST_DEPTH;
		end else if (cfg_wr) begin
			unique case (cfg_index)
				REG_POS_X: pos_x_q <= cfg_data[COORD_W-1:0];
				REG_POS_Y: pos_y_q <= cfg_data[COORD_W-1:0];
				REG_POS_Z: pos_z_q <= cfg_data[COORD_W-1:0];
				REG_TILT:  tilt_q  <= cfg_data[ANG_W-1:0];
				REG_AZIM:  azim_q  <= cfg_data[ANG_W-1:0];
				REG_WIDTH: width_q <= cfg_data[EXT_W-1:0];
				REG_DEPTH: depth_q <= cfg_data[EXT_W-1:0];
				default: ;
			endcase
		end
	end

	obrh_trig u_trig (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cfg_wr),
		.tilt   (tilt_q),
		.azim   (azim_q),
		.rdy    (trig_rdy),
		.trig   (trig)
	);

	obrh_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.acc      (acc),
		.origin_x (origin_x),
		.origin_y (origin_y),
		.origin_z (origin_z),
		.dir_x    (dir_x),
		.dir_y    (dir_y),
		.dir_z    (dir_z),
		.pos_x    (pos_x_q),
		.pos_y    (pos_y_q),
		.pos_z    (pos_z_q),
		.width    (width_q),
		.depth    (depth_q),
		.trig     (trig),
		.qs       (q_stat),
		.en       (f_en),
		.push     (q_push),
		.entry    (q_wdata)
	);

	obrh_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.head   (q_head),
		.qs     (q_stat)
	);

	obrh_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.qs        (q_stat),
		.head      (q_head),
		.out_ready (out_ready),
		.pop       (q_pop),
		.out_valid (out_valid),
		.hit       (hit)
	);

`ifndef ASSERT_OFF
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_stat.full)
		else $error("queue pushed while full");
	a_pop_data: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_stat.empty)
		else $error("queue popped while empty");
	a_cfg_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr |=> !in_ready)
		else $error("item taken before coefficients were recomputed");
`endif

endmodule
